>>> rtl/core/fmrss_pkg.sv
`default_nettype none

package fmrss_pkg;

	// command codes carried in s_tuser
	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_BYTE  = 3'd1,
		CMD_EOS   = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	// stream parser state
	typedef enum logic [1:0] {
		PH_CODE  = 2'd0,
		PH_VALUE = 2'd1,
		PH_LOAD  = 2'd2
	} phase_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_DLY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LEN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP      = 2'd3;

	// codemap index taken from a code byte
	localparam int MAP_IDX_W = 7;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// one classified word for the back end
	typedef struct packed {
		logic                 map_wr;
		logic                 map_rd;
		logic                 emit;
		logic                 bank;
		logic [MAP_IDX_W-1:0] idx;
		logic [7:0]           data;
		logic                 playing;
		logic                 wants;
		logic                 dropped;
	} q_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/fm_register_stream_sequencer.sv
// fm register stream sequencer
//
// s_* carries one command word per handshake: tuser is the command (tick,
// stream byte, end of stream, start, stop), tdata the tick's elapsed
// milliseconds and the stream byte. every accepted word gives exactly one
// m_* word: an optional synthesizer register write (tuser) plus the
// playing, wants_byte and byte_dropped status after that command.
// cfg_* writes the delay codes, codemap length and loop enable; it is
// always ready and should only be used while the block is idle.
//
// throughput is one word per cycle while m_tready stays high. an accepted
// word is written into the queue by the front parser, then popped through
// the codemap lookup into the output register of the back end.
// when m_tready is held low the back end stops popping and the four entry
// queue fills; s_tready then drops until the receiver takes a word.
// reset clears the codemap at once through per-entry valid bits, so the
// block accepts words as soon as reset is released.
`default_nettype none

module fm_register_stream_sequencer
	import fmrss_pkg::*;
#(
	parameter int CODEMAP_DEPTH = 128,
	parameter int DUE_WIDTH     = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command word in
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,   // elapsed_ms[15:0], data_byte[23:16]
	input  wire logic [2:0]           s_tuser,   // command[2:0]
	// result word out
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,   // reg_address[8:0], reg_value[16:9],
	                                             // playing[17], wants_byte[18],
	                                             // byte_dropped[19], zero fill
	output logic [0:0]                m_tuser,   // write_valid[0]
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic       accept;
	q_entry_t   push_entry;
	q_entry_t   head;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	logic       write_valid;
	logic [8:0] reg_address;
	logic [7:0] reg_value;
	logic       playing;
	logic       wants_byte;
	logic       byte_dropped;

	assign cfg_ready = 1'b1;
	// the front never waits on anything but queue space
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;

	fmrss_front #(
		.CODEMAP_DEPTH(CODEMAP_DEPTH),
		.DUE_WIDTH    (DUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.command   (s_tuser),
		.elapsed_ms(s_tdata[15:0]),
		.data_byte (s_tdata[23:16]),
		.entry     (push_entry)
	);

	fmrss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	fmrss_back #(
		.CODEMAP_DEPTH(CODEMAP_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.write_valid (write_valid),
		.reg_address (reg_address),
		.reg_value   (reg_value),
		.playing     (playing),
		.wants_byte  (wants_byte),
		.byte_dropped(byte_dropped)
	);

	assign m_tdata = {4'd0, byte_dropped, wants_byte, playing, reg_value, reg_address};
	assign m_tuser = write_valid;

	// a word is only pushed with room in the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !q_full)
		else $error("queue push while full");

	// each queued word does at most one codemap or write action
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> $onehot0({push_entry.map_wr, push_entry.map_rd, push_entry.emit}))
		else $error("queued word carries more than one action");

	// asking for bytes only makes sense while playing
	a_wants_playing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!wants_byte || playing))
		else $error("wants_byte without playing");

	// a dropped byte never turns into a register write
	a_drop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && write_valid |-> !byte_dropped)
		else $error("register write from a dropped byte");

	// an empty queue pops nothing
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/core/fmrss_ram.sv
`default_nettype none

module fmrss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic                  re,
	input  wire logic [AW-1:0]         raddr,
	output logic      [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/fmrss_front.sv
`default_nettype none

module fmrss_front
	import fmrss_pkg::*;
#(
	parameter int CODEMAP_DEPTH = 128,
	parameter int DUE_WIDTH     = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 accept,
	input  wire logic [2:0]           command,
	input  wire logic [15:0]          elapsed_ms,
	input  wire logic [7:0]           data_byte,
	output q_entry_t                  entry
);

	localparam logic [7:0] DEPTH_L = 8'(CODEMAP_DEPTH);

	logic [7:0]           short_dly_q;
	logic [7:0]           long_dly_q;
	logic [7:0]           map_len_q;
	logic                 loop_q;

	phase_t               phase_q, phase_d;
	logic [MAP_IDX_W-1:0] load_q, load_d;
	logic [7:0]           held_q, held_d;
	logic [DUE_WIDTH-1:0] due_q, due_d;
	logic                 play_q, play_d;

	cmd_t                 cmd;
	logic [7:0]           eff_len;
	phase_t               begin_phase;
	logic                 wanted;
	logic                 last_load;
	logic [DUE_WIDTH:0]   diff;
	logic [8:0]           inc9;
	logic [DUE_WIDTH-1:0] short_add;
	logic [DUE_WIDTH-1:0] long_add;

	assign cmd         = cmd_t'(command);
	assign eff_len     = (map_len_q > DEPTH_L) ? DEPTH_L : map_len_q;
	assign begin_phase = (eff_len != 8'd0) ? PH_LOAD : PH_CODE;
	assign wanted      = play_q && (due_q[DUE_WIDTH-1] || (due_q == '0));
	assign last_load   = (({1'b0, load_q}) + 8'd1) >= eff_len;
	// sign bits differ on underflow below the lowest count
	assign diff        = {due_q[DUE_WIDTH-1], due_q}
	                     - {{(DUE_WIDTH-15){1'b0}}, elapsed_ms};
	assign inc9        = {1'b0, data_byte} + 9'd1;
	assign short_add   = {{(DUE_WIDTH-9){1'b0}}, inc9};
	assign long_add    = {{(DUE_WIDTH-17){1'b0}}, inc9, 8'd0};

	// parser next state
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (cmd)
				CMD_BYTE: begin
					if (wanted) begin
						unique case (phase_q)
							PH_LOAD:  phase_d = last_load ? PH_CODE : PH_LOAD;
							PH_CODE:  phase_d = PH_VALUE;
							PH_VALUE: phase_d = PH_CODE;
							default:  phase_d = PH_CODE;
						endcase
					end
				end
				CMD_EOS: begin
					if (wanted && (phase_q == PH_CODE) && loop_q) begin
						phase_d = begin_phase;
					end
				end
				CMD_START: phase_d = begin_phase;
				default:   phase_d = phase_q;
			endcase
		end
	end

	// counters, flags and the word for the back end
	always_comb begin
		play_d = play_q;
		due_d  = due_q;
		load_d = load_q;
		held_d = held_q;
		entry  = '0;
		if (accept) begin
			unique case (cmd)
				CMD_TICK: begin
					if (play_q) begin
						if (diff[DUE_WIDTH] != diff[DUE_WIDTH-1]) begin
							due_d = {1'b1, {(DUE_WIDTH-1){1'b0}}};
						end else begin
							due_d = diff[DUE_WIDTH-1:0];
						end
					end
				end
				CMD_BYTE: begin
					if (!wanted) begin
						entry.dropped = 1'b1;
					end else begin
						unique case (phase_q)
							PH_LOAD: begin
								entry.map_wr = 1'b1;
								entry.idx    = load_q;
								entry.data   = data_byte;
								load_d       = last_load ? '0 : load_q + 7'd1;
							end
							PH_CODE: begin
								held_d       = data_byte;
								entry.map_rd = 1'b1;
								entry.idx    = data_byte[MAP_IDX_W-1:0];
							end
							PH_VALUE: begin
								if (held_q == short_dly_q) begin
									due_d = due_q + short_add;
								end else if (held_q == long_dly_q) begin
									due_d = due_q + long_add;
								end else begin
									entry.emit = 1'b1;
									entry.bank = held_q[7];
									entry.data = data_byte;
								end
							end
							default: begin
							end
						endcase
					end
				end
				CMD_EOS: begin
					if (!wanted) begin
						entry.dropped = 1'b1;
					end else if ((phase_q == PH_CODE) && loop_q) begin
						due_d  = '0;
						load_d = '0;
					end else begin
						play_d = 1'b0;
					end
				end
				CMD_START: begin
					play_d = 1'b1;
					due_d  = '0;
					load_d = '0;
				end
				CMD_STOP: play_d = 1'b0;
				default: begin
				end
			endcase
		end
		entry.playing = play_d;
		entry.wants   = play_d && (due_d[DUE_WIDTH-1] || (due_d == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_dly_q <= 8'd0;
			long_dly_q  <= 8'd1;
			map_len_q   <= 8'd0;
			loop_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHORT_DLY: short_dly_q <= cfg_data;
				CFG_LONG_DLY:  long_dly_q  <= cfg_data;
				CFG_MAP_LEN:   map_len_q   <= cfg_data;
				CFG_LOOP:      loop_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			load_q  <= '0;
			held_q  <= '0;
			due_q   <= '0;
			play_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			load_q  <= load_d;
			held_q  <= held_d;
			due_q   <= due_d;
			play_q  <= play_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/fmrss_queue.sv
`default_nettype none

module fmrss_queue
	import fmrss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_entry,
	input  wire logic     pop,
	output q_entry_t      head,
	output logic          full,
	output logic          empty
);

	q_entry_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/fmrss_back.sv
`default_nettype none

module fmrss_back
	import fmrss_pkg::*;
#(
	parameter int CODEMAP_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire q_entry_t    head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             write_valid,
	output logic [8:0]       reg_address,
	output logic [7:0]       reg_value,
	output logic             playing,
	output logic             wants_byte,
	output logic             byte_dropped
);

	localparam int         AW      = (CODEMAP_DEPTH > 1) ? $clog2(CODEMAP_DEPTH) : 1;
	localparam logic [7:0] DEPTH_L = 8'(CODEMAP_DEPTH);

	logic [CODEMAP_DEPTH-1:0] valid_q;
	logic                     hit_q;
	logic                     in_range;
	logic [AW-1:0]            addr;
	logic [7:0]               rdata;
	logic [7:0]               base;
	logic                     out_valid_q;
	logic                     wv_q;
	logic [8:0]               addr_q;
	logic [7:0]               value_q;
	logic                     playing_q;
	logic                     wants_q;
	logic                     dropped_q;

	assign pop      = !empty && (!out_valid_q || out_ready);
	assign in_range = ({1'b0, head.idx} < DEPTH_L);
	assign addr     = head.idx[AW-1:0];
	// entries never written read as zero
	assign base     = hit_q ? rdata : 8'd0;

	fmrss_ram #(
		.WIDTH(8),
		.DEPTH(CODEMAP_DEPTH)
	) u_codemap (
		.clk  (clk),
		.we   (pop && head.map_wr && in_range),
		.waddr(addr),
		.wdata(head.data),
		.re   (pop && head.map_rd),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.map_wr && in_range) begin
				valid_q[addr] <= 1'b1;
			end
			if (pop && head.map_rd) begin
				hit_q <= in_range && valid_q[addr];
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wv_q      <= head.emit;
			addr_q    <= head.emit ? {head.bank, base} : 9'd0;
			value_q   <= head.emit ? head.data : 8'd0;
			playing_q <= head.playing;
			wants_q   <= head.wants;
			dropped_q <= head.dropped;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_valid  = wv_q;
	assign reg_address  = addr_q;
	assign reg_value    = value_q;
	assign playing      = playing_q;
	assign wants_byte   = wants_q;
	assign byte_dropped = dropped_q;

endmodule

`default_nettype wire

>>> tb/sv/fm_register_stream_sequencer_test.sv
`timescale 1ns / 1ps

module fm_register_stream_sequencer_test
	import fmrss_pkg::*;
();

	localparam int MAP_DEPTH = 128;
	localparam longint DUE_LOWEST = -(longint'(1) << 23);
	// command codes the block treats as no operation
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

	// one result word, fields as the block reports them
	typedef struct packed {
		logic       write_valid;
		logic [8:0] reg_address;
		logic [7:0] reg_value;
		logic       playing;
		logic       wants_byte;
		logic       byte_dropped;
	} fm_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	fm_register_stream_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// player state mirrored in the testbench
	logic [7:0] pl_short_dly;
	logic [7:0] pl_long_dly;
	logic [7:0] pl_map_len;
	logic pl_loop;
	logic [7:0] pl_map [MAP_DEPTH];
	phase_t pl_phase;
	logic [6:0] pl_load_idx;
	logic [7:0] pl_held;
	logic signed [23:0] pl_due;
	logic pl_play;
	// set when the last predicted word changed nothing
	logic word_ignored;

	fm_result_t expected_results [$];
	int mismatch_count = 0;
	int burst_left = 0;

	fm_result_t got_word;
	fm_result_t want_word;

	// receiver stall pattern state
	int rx_span = 0;
	int rx_mode = 0;
	int rx_run = 0;
	logic rx_stall = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// safety net: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// codemap bytes actually loaded, capped at the table size
	function automatic int map_fill_len();
		return (pl_map_len > MAP_DEPTH) ? MAP_DEPTH : int'(pl_map_len);
	endfunction

	// stream (re)start: clear the due counter, load codemap if it has a length
	function automatic void restart_stream();
		pl_due = '0;
		pl_load_idx = '0;
		pl_phase = (map_fill_len() > 0) ? PH_LOAD : PH_CODE;
	endfunction

	// predict the result word of one command word and advance the player
	function automatic fm_result_t play_stream_word(logic [2:0] cmd, logic [15:0] ms,
			logic [7:0] b);
		fm_result_t r;
		longint d;
		logic wanted;
		r = '0;
		wanted = pl_play && (pl_due <= 0);
		word_ignored = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (pl_play) begin
					d = longint'(pl_due) - longint'({1'b0, ms});
					// the due counter saturates at its most negative value
					if (d < DUE_LOWEST)
						d = DUE_LOWEST;
					pl_due = d[23:0];
				end else begin
					word_ignored = 1'b1;
				end
			end
			CMD_BYTE: begin
				if (!wanted) begin
					r.byte_dropped = 1'b1;
					word_ignored = 1'b1;
				end else if (pl_phase == PH_LOAD) begin
					pl_map[pl_load_idx] = b;
					if (int'(pl_load_idx) + 1 >= map_fill_len()) begin
						pl_phase = PH_CODE;
						pl_load_idx = '0;
					end else begin
						pl_load_idx = pl_load_idx + 7'd1;
					end
				end else if (pl_phase == PH_CODE) begin
					pl_held = b;
					pl_phase = PH_VALUE;
				end else begin
					pl_phase = PH_CODE;
					// short delay wins when both delay codes match
					if (pl_held == pl_short_dly) begin
						d = longint'(pl_due) + longint'({1'b0, b}) + 1;
						pl_due = d[23:0];
					end else if (pl_held == pl_long_dly) begin
						d = longint'(pl_due) + (longint'({1'b0, b}) + 1) * 256;
						pl_due = d[23:0];
					end else begin
						r.write_valid = 1'b1;
						r.reg_address = {pl_held[7], pl_map[pl_held[6:0]]};
						r.reg_value = b;
					end
				end
			end
			CMD_EOS: begin
				if (!wanted) begin
					r.byte_dropped = 1'b1;
					word_ignored = 1'b1;
				end else if (pl_phase == PH_CODE && pl_loop) begin
					restart_stream();
				end else begin
					pl_play = 1'b0;
				end
			end
			CMD_START: begin
				pl_play = 1'b1;
				restart_stream();
			end
			CMD_STOP: pl_play = 1'b0;
			default: word_ignored = 1'b1;
		endcase
		r.playing = pl_play;
		r.wants_byte = pl_play && (pl_due <= 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		// keep the log short on a badly broken block
		if (mismatch_count <= 40)
			$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
	endtask

	// send one command word; the sender runs in bursts with random gaps
	task automatic send_word(input logic [2:0] cmd, input logic [15:0] ms, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {b, ms};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(play_stream_word(cmd, ms, b));
	endtask

	task automatic put_byte(input logic [7:0] b);
		send_word(CMD_BYTE, 16'($urandom_range(0, 65535)), b);
	endtask

	task automatic put_pair(input logic [7:0] code, input logic [7:0] value);
		put_byte(code);
		put_byte(value);
	endtask

	task automatic tick(input logic [15:0] ms);
		send_word(CMD_TICK, ms, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_cmd(input logic [2:0] cmd);
		send_word(cmd, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
	endtask

	// hold the sender until every outstanding word has come back
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		wait_drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SHORT_DLY: pl_short_dly = value;
			CFG_LONG_DLY: pl_long_dly = value;
			CFG_MAP_LEN: pl_map_len = value;
			CFG_LOOP: pl_loop = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic [7:0] short_dly, input logic [7:0] long_dly,
			input logic [7:0] map_len, input logic loop_en);
		write_setting(CFG_SHORT_DLY, short_dly);
		write_setting(CFG_LONG_DLY, long_dly);
		write_setting(CFG_MAP_LEN, map_len);
		write_setting(CFG_LOOP, {7'd0, loop_en});
	endtask

	// commands that must do nothing while stopped
	task automatic test_idle_commands();
		logic [2:0] c;
		tick(16'h0000);
		tick(16'hFFFF);
		put_byte(8'h00);
		put_byte(8'hFF);
		send_cmd(CMD_EOS);
		for (c = CMD_SPARE_FIRST; c != CMD_SPARE_LAST; c++)
			send_cmd(c);
		send_cmd(CMD_SPARE_LAST);
		send_cmd(CMD_STOP);
	endtask

	// reset settings: short code 0, long code 1, no codemap, no loop
	task automatic test_default_stream();
		send_cmd(CMD_START);
		put_pair(8'h00, 8'h03);
		put_byte(8'h55);
		send_cmd(CMD_EOS);
		tick(16'd3);
		tick(16'd1);
		put_pair(8'h01, 8'h00);
		tick(16'hFFFF);
		put_pair(8'h85, 8'hA5);
		put_pair(8'h7F, 8'hFF);
		put_pair(8'hFF, 8'h00);
		// stop in the middle of a pair, start again at a code byte
		put_byte(8'h02);
		send_cmd(CMD_STOP);
		send_cmd(CMD_START);
		send_cmd(CMD_EOS);
	endtask

	// short codemap, equal delay codes, looping and the end-of-stream cases
	task automatic test_codemap_load();
		apply_settings(8'hFF, 8'hFF, 8'd3, 1'b1);
		send_cmd(CMD_START);
		put_byte(8'h12);
		tick(16'd5);
		put_byte(8'hAB);
		put_byte(8'h34);
		put_pair(8'h00, 8'h55);
		put_pair(8'h81, 8'h01);
		put_pair(8'hFF, 8'h02);
		put_byte(8'h03);
		send_cmd(CMD_EOS);
		send_cmd(CMD_START);
		put_byte(8'h01);
		send_cmd(CMD_EOS);
		send_cmd(CMD_START);
		put_byte(8'hC0);
		put_byte(8'hC1);
		put_byte(8'hC2);
		send_cmd(CMD_EOS);
		put_byte(8'h5A);
		put_byte(8'hA5);
		put_byte(8'h0F);
		put_pair(8'h02, 8'h77);
		send_cmd(CMD_STOP);
	endtask

	// codemap length above the table size loads only the full table
	task automatic test_long_codemap();
		int k;
		apply_settings(8'hFE, 8'hFD, 8'd200, 1'b0);
		send_cmd(CMD_START);
		for (k = 0; k < MAP_DEPTH; k++)
			put_byte(8'($urandom_range(0, 255)));
		put_pair(8'h7F, 8'h11);
		put_pair(8'hFF, 8'h22);
		put_pair(8'h00, 8'h33);
		put_pair(8'h80, 8'h44);
		send_cmd(CMD_STOP);
	endtask

	// drive the due counter into its lower bound, then climb back to zero
	task automatic test_due_saturation();
		int k;
		apply_settings(8'h10, 8'h20, 8'd0, 1'b0);
		send_cmd(CMD_START);
		for (k = 0; k < 130; k++)
			tick(16'hFFFF);
		// 128 long delays of 65536 land exactly on zero only if it saturated
		for (k = 0; k < 128; k++)
			put_pair(8'h20, 8'hFF);
		put_pair(8'h10, 8'h00);
		tick(16'd1);
		send_cmd(CMD_STOP);
	endtask

	task automatic randomize_settings(input int phase_no);
		logic [7:0] len;
		logic [7:0] sc;
		case ($urandom_range(0, 19))
			0: len = 8'd128;
			1: len = 8'd255;
			2: len = 8'd127;
			3: len = 8'd0;
			4: len = 8'd1;
			default: len = 8'($urandom_range(1, 12));
		endcase
		sc = 8'($urandom_range(0, 255));
		// the first two phases pin the code extremes
		if (phase_no == 0)
			apply_settings(8'h00, 8'hFF, 8'd128, 1'b1);
		else if (phase_no == 1)
			apply_settings(8'hFF, 8'h00, 8'd0, 1'b0);
		else if ($urandom_range(0, 7) == 0)
			apply_settings(sc, sc, len, 1'($urandom_range(0, 1)));
		else
			apply_settings(sc, 8'($urandom_range(0, 255)), len, 1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed streams with random content, some noise and breaks
	task automatic test_random_play(input int n_words);
		int done;
		int phase_no;
		int r;
		logic [7:0] code;
		logic [15:0] ms;
		done = 0;
		phase_no = 0;
		while (done < n_words) begin
			if (done >= phase_no * 175) begin
				randomize_settings(phase_no);
				phase_no++;
			end
			if ($urandom_range(0, 49) == 0)
				wait_drain();
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_cmd(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
			end else if (r < 4) begin
				send_cmd(CMD_STOP);
			end else if (!pl_play) begin
				if (r < 70)
					send_cmd(CMD_START);
				else
					send_cmd(3'($urandom_range(CMD_TICK, CMD_EOS)));
			end else if (pl_due <= 0) begin
				if (r < 10) begin
					tick(16'($urandom_range(0, 65535)));
				end else if (r < 12) begin
					send_cmd(CMD_EOS);
				end else if (pl_phase == PH_CODE) begin
					case ($urandom_range(0, 9))
						0, 1, 2: code = pl_short_dly;
						3, 4: code = pl_long_dly;
						default: code = 8'($urandom_range(0, 255));
					endcase
					put_byte(code);
				end else begin
					put_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				if (r < 80) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: ms = (pl_due > 65535) ? 16'hFFFF : pl_due[15:0];
						4, 5, 6: ms = 16'($urandom_range(0, 255));
						default: ms = 16'($urandom_range(0, 65535));
					endcase
					tick(ms);
				end else if (r < 92) begin
					put_byte(8'($urandom_range(0, 255)));
				end else begin
					send_cmd(CMD_EOS);
				end
			end
			if (!word_ignored)
				done++;
		end
	endtask

	// receiver: ready always, coin flips, long stalls or rare stalls
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_span = $urandom_range(20, 300);
			rx_mode = $urandom_range(0, 3);
			rx_run = 0;
		end
		rx_span--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: begin
				if (rx_run == 0) begin
					rx_stall = !rx_stall;
					rx_run = rx_stall ? $urandom_range(1, 30) : $urandom_range(1, 8);
				end
				rx_run--;
				m_tready <= !rx_stall;
			end
			default: m_tready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// compare every taken result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word.write_valid = m_tuser[0];
			got_word.reg_address = m_tdata[8:0];
			got_word.reg_value = m_tdata[16:9];
			got_word.playing = m_tdata[17];
			got_word.wants_byte = m_tdata[18];
			got_word.byte_dropped = m_tdata[19];
			if (expected_results.size() == 0) begin
				report_mismatch("word with nothing pending", got_word, 0);
			end else begin
				want_word = expected_results.pop_front();
				if (got_word.write_valid !== want_word.write_valid)
					report_mismatch("write_valid", got_word.write_valid, want_word.write_valid);
				if (got_word.reg_address !== want_word.reg_address)
					report_mismatch("reg_address", got_word.reg_address, want_word.reg_address);
				if (got_word.reg_value !== want_word.reg_value)
					report_mismatch("reg_value", got_word.reg_value, want_word.reg_value);
				if (got_word.playing !== want_word.playing)
					report_mismatch("playing", got_word.playing, want_word.playing);
				if (got_word.wants_byte !== want_word.wants_byte)
					report_mismatch("wants_byte", got_word.wants_byte, want_word.wants_byte);
				if (got_word.byte_dropped !== want_word.byte_dropped)
					report_mismatch("byte_dropped", got_word.byte_dropped,
						want_word.byte_dropped);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_TICK;
		cfg_valid = 1'b0;
		cfg_index = CFG_SHORT_DLY;
		cfg_data = '0;
		// player state after reset
		pl_short_dly = 8'h00;
		pl_long_dly = 8'h01;
		pl_map_len = 8'h00;
		pl_loop = 1'b0;
		for (int k = 0; k < MAP_DEPTH; k++)
			pl_map[k] = 8'h00;
		pl_phase = PH_CODE;
		pl_load_idx = '0;
		pl_held = '0;
		pl_due = '0;
		pl_play = 1'b0;
		word_ignored = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_commands();
		test_default_stream();
		test_codemap_load();
		test_long_codemap();
		test_due_saturation();
		test_random_play(700);

		// let the pipe empty, then watch for stray words
		wait_drain();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("words never delivered", 0, expected_results.size());
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
